// ===== src/mie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mie_pkg - shared constants for the modular inverse block
// Sequencer state codes used by the extended Euclid datapath.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Sequencer state encoding
  localparam int unsigned StateW = 3;

  localparam logic [StateW-1:0] StIdle   = 3'd0;  // waiting for an item
  localparam logic [StateW-1:0] StCheck  = 3'd1;  // test remainder for zero
  localparam logic [StateW-1:0] StDiv    = 3'd2;  // one quotient bit per cycle
  localparam logic [StateW-1:0] StUpdate = 3'd3;  // rotate remainders and coefficients
  localparam logic [StateW-1:0] StFinish = 3'd4;  // sign fixup, hand off result

endpackage
`default_nettype wire

// ===== src/modular_inverse_ext_euclid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid - modular inverse by extended Euclid
// Returns the first Bezout coefficient of (value, modulus), made nonnegative
// by adding the modulus once. A zero modulus yields 1.
// ----------------------------------------------------------------------------
// One item is processed at a time. Each Euclid round runs a zero check, then a
// radix-2 restoring divider over all WIDTH quotient bits, folding each quotient
// bit into the q*x product by shift-and-add in the same cycle, then an update of
// remainders and coefficients. After acceptance an item passes through the
// rounds, a final zero check and the sign fixup before the result is handed
// off, and the next item is accepted once the sequencer is back in idle. At
// WIDTH = 64 there are up to about 93 rounds. The single shared divide and
// multiply-accumulate step sets the length of each round. The input stalls
// while an item is in flight; the result sits in an output register so a new
// item can be accepted while it waits to be taken.
module modular_inverse_ext_euclid #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input items
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WIDTH-1:0] value_i,
  input  wire logic [WIDTH-1:0] modulus_i,
  // result items
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [WIDTH-1:0] inverse_o
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);

  // Control registers
  logic [mie_pkg::StateW-1:0] state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;

  // Datapath registers
  logic [WIDTH-1:0] mod_q, mod_d;
  logic [WIDTH-1:0] r_old_q, r_old_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] m_old_q, m_old_d;
  logic [WIDTH-1:0] m_cur_q, m_cur_d;
  logic             n_old_q, n_old_d;
  logic             n_cur_q, n_cur_d;
  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] qm_q, qm_d;
  logic [WIDTH-1:0] inv_q, inv_d;

  // Divider step: shift in next dividend bit, trial subtract
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH+1:0] trial;
  logic             qbit;
  logic [WIDTH-1:0] qm_step;

  assign rem_sh  = {rem_q, dvd_q[WIDTH-1]};
  assign trial   = {1'b0, rem_sh} - {2'b00, r_q};
  assign qbit    = ~trial[WIDTH+1];
  // Horner accumulation of q*m_cur, MSB-first quotient bits
  assign qm_step = {qm_q[WIDTH-2:0], 1'b0} + (qbit ? m_cur_q : '0);

  assign in_stall_o  = (state_q != mie_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign inverse_o   = inv_q;

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    mod_d       = mod_q;
    r_old_d     = r_old_q;
    r_d         = r_q;
    m_old_d     = m_old_q;
    m_cur_d     = m_cur_q;
    n_old_d     = n_old_q;
    n_cur_d     = n_cur_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    qm_d        = qm_q;
    inv_d       = inv_q;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mie_pkg::StIdle: begin
        if (in_valid_i) begin
          mod_d   = modulus_i;
          r_old_d = value_i;
          r_d     = modulus_i;
          m_old_d = {{(WIDTH-1){1'b0}}, 1'b1};
          m_cur_d = '0;
          n_old_d = 1'b0;
          n_cur_d = 1'b0;
          state_d = mie_pkg::StCheck;
        end
      end
      mie_pkg::StCheck: begin
        if (r_q == '0) begin
          state_d = mie_pkg::StFinish;
        end else begin
          dvd_d   = r_old_q;
          rem_d   = '0;
          qm_d    = '0;
          cnt_d   = CntLast;
          state_d = mie_pkg::StDiv;
        end
      end
      mie_pkg::StDiv: begin
        rem_d = qbit ? trial[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        dvd_d = {dvd_q[WIDTH-2:0], 1'b0};
        qm_d  = qm_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = mie_pkg::StUpdate;
        end
      end
      mie_pkg::StUpdate: begin
        // signs alternate, so magnitudes add
        r_old_d = r_q;
        r_d     = rem_q;
        m_old_d = m_cur_q;
        n_old_d = n_cur_q;
        m_cur_d = m_old_q + qm_q;
        n_cur_d = (qm_q != '0) ? ~n_cur_q : n_old_q;
        state_d = mie_pkg::StCheck;
      end
      mie_pkg::StFinish: begin
        // wait until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          inv_d       = (n_old_q && (m_old_q != '0)) ? (mod_q - m_old_q) : m_old_q;
          out_valid_d = 1'b1;
          state_d     = mie_pkg::StIdle;
        end
      end
      default: begin
        state_d = mie_pkg::StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mie_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mod_q   <= mod_d;
    r_old_q <= r_old_d;
    r_q     <= r_d;
    m_old_q <= m_old_d;
    m_cur_q <= m_cur_d;
    n_old_q <= n_old_d;
    n_cur_q <= n_cur_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    qm_q    <= qm_d;
    inv_q   <= inv_d;
  end

endmodule
`default_nettype wire
